// ----- sv/ssop_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ssop_pkg;

   // field widths
   localparam int unsigned XTAL_W  = 28;
   localparam int unsigned TRIM_W  = 21;
   localparam int unsigned FREQ_W  = 28;
   localparam int unsigned FX_W    = 29;
   localparam int unsigned MS_W    = 11;
   localparam int unsigned FVCO_W  = 32;
   localparam int unsigned FRAC_W  = 20;
   localparam int unsigned FL_W    = 7;
   localparam int unsigned RDIV_W  = 3;
   localparam int unsigned DRIVE_W = 2;
   localparam int unsigned CSEL_W  = 2;
   localparam int unsigned IDX_W   = 5;
   localparam int unsigned CSR_IDX_W = 3;

   // shared divider geometry
   localparam int unsigned DIVD_W = 50;
   localparam int unsigned DIVR_W = 30;
   localparam int unsigned CNT_W  = $clog2(DIVD_W + 1);

   // plan constants
   localparam logic [FRAC_W-1:0] FRAC_DEN     = 20'd1048575;
   localparam logic [DIVR_W-1:0] VCO_MAX_HZ   = 30'd900000000;
   localparam logic [FVCO_W-1:0] VCO_MIN_HZ   = 32'd600000000;
   localparam logic [FREQ_W-1:0] LOW_FREQ_HZ  = 28'd500000;
   localparam logic [MS_W-1:0]   DIV_MIN      = 11'd6;
   localparam logic [MS_W-1:0]   DIV_MAX      = 11'd1800;
   localparam logic [RDIV_W-1:0] RDIV_MAX     = 3'd7;
   localparam logic [DIVR_W-1:0] BILLION      = 30'd1000000000;
   localparam logic signed [DIVD_W-1:0] HALF_BILLION = 50'sd500000000;
   localparam logic [IDX_W-1:0]  LAST_IDX     = 5'd18;

   // device register map
   localparam logic [7:0] ADDR_PLL_A   = 8'd26;
   localparam logic [7:0] ADDR_PLL_B   = 8'd34;
   localparam logic [7:0] ADDR_MS      = 8'd42;
   localparam logic [7:0] ADDR_PHASE   = 8'd165;
   localparam logic [7:0] ADDR_CTRL    = 8'd16;
   localparam logic [7:0] ADDR_PLL_RST = 8'd177;
   localparam logic [7:0] CTRL_BASE    = 8'h4C;
   localparam logic [7:0] CTRL_PLL_B   = 8'h20;
   localparam logic [7:0] RST_PLL_A    = 8'h20;
   localparam logic [7:0] RST_PLL_B    = 8'h80;

   // clock select codes
   localparam logic [CSEL_W-1:0] CSEL_CLK0 = 2'd0;
   localparam logic [CSEL_W-1:0] CSEL_CLK1 = 2'd1;
   localparam logic [CSEL_W-1:0] CSEL_CLK2 = 2'd2;
   localparam logic [CSEL_W-1:0] CSEL_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRYSTAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE0  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE2  = 3'd4;

   typedef struct packed {
      logic [CSEL_W-1:0] clock_select;
      logic [FREQ_W-1:0] frequency_hz;
   } req_type;

   typedef struct packed {
      logic [7:0] reg_address;
      logic [7:0] reg_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [XTAL_W-1:0]        crystal_hz;
      logic signed [TRIM_W-1:0] trim_ppb;
      logic [DRIVE_W-1:0]       drive_clk0;
      logic [DRIVE_W-1:0]       drive_clk1;
      logic [DRIVE_W-1:0]       drive_clk2;
   } csr_type;

   typedef struct packed {
      logic [CSEL_W-1:0]  clock_select;
      logic [RDIV_W-1:0]  rdiv;
      logic [MS_W-1:0]    ms;
      logic [31:0]        a;
      logic [FRAC_W-1:0]  b;
      logic [FL_W-1:0]    fl;
      logic [DRIVE_W-1:0] drive;
   } plan_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
      logic [DIVR_W-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_XMUL,
      ST_XDIV,
      ST_XWAIT,
      ST_DOUBLE,
      ST_MSDIV,
      ST_MSWAIT,
      ST_VMUL,
      ST_VCHK,
      ST_ADIV,
      ST_AWAIT,
      ST_BDIV,
      ST_BWAIT,
      ST_FDIV,
      ST_FWAIT,
      ST_EMIT,
      ST_EWAIT
   } plan_state_type;

endpackage
`default_nettype wire

// ----- sv/synth_single_output_plan.sv -----
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/stall    | req_type: clock_select, frequency_hz
//  rsp_     | out       | rsp_valid/stall    | rsp_type: reg_address, reg_data, last
//  csr_     | in        | csr_valid/ready    | csr_index, csr_data
//
//  a request runs its arithmetic, then the 19 beats load out; the arithmetic
//  uses five 50-step divisions on the one shared restoring divider, fewer
//  when the crystal is zero
//  synchronous active-high reset; config returns to its power-on values
//  req_stall is high from acceptance until the last beat is loaded out
//  rsp_stall holds the output register; clock select three is taken and dropped
`timescale 1ns / 1ps
`default_nettype none
module synth_single_output_plan
   import ssop_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   // register write beats
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   // configuration
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [XTAL_W-1:0]    csr_data
);

   csr_type     csr_ff, csr_in;
   div_req_type div_req;
   div_rsp_type div_rsp;
   plan_type    plan;
   logic        emit_start;
   logic        emit_busy;

   // config writes are always taken; indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CRYSTAL: csr_in.crystal_hz = csr_data;
            CSR_TRIM:    csr_in.trim_ppb   = $signed(csr_data[TRIM_W-1:0]);
            CSR_DRIVE0:  csr_in.drive_clk0 = csr_data[DRIVE_W-1:0];
            CSR_DRIVE1:  csr_in.drive_clk1 = csr_data[DRIVE_W-1:0];
            CSR_DRIVE2:  csr_in.drive_clk2 = csr_data[DRIVE_W-1:0];
            default:     csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.crystal_hz <= XTAL_W'(25000000);
         csr_ff.trim_ppb   <= '0;
         csr_ff.drive_clk0 <= 2'd3;
         csr_ff.drive_clk1 <= 2'd3;
         csr_ff.drive_clk2 <= 2'd3;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // sequencer: crystal trim, doubling, divider pick, feedback a, b and floor
   ssop_plan u_plan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr        (csr_ff),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .emit_start (emit_start),
      .emit_busy  (emit_busy),
      .plan       (plan)
   );

   // shared divider, one bit per cycle
   ssop_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // packs both blocks and streams the 19 writes through an output register
   ssop_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .emit_start (emit_start),
      .plan       (plan),
      .emit_busy  (emit_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ----- sv/ssop_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssop_div
   import ssop_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dsr_ff, dsr_in;
   logic [DIVR_W:0]   shifted;
   logic [DIVR_W+1:0] diff;
   logic              fits;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b0, dsr_ff};
   assign fits    = ~diff[DIVR_W+1];

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         cnt_in = CNT_W'(DIVD_W);
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
         quo_in  = {quo_ff[DIVD_W-2:0], fits};
         rem_in  = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

// ----- sv/ssop_plan.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssop_plan
   import ssop_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   input  wire csr_type     csr,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp,
   output logic             emit_start,
   input  wire logic        emit_busy,
   output plan_type         plan
);

   plan_state_type state_ff, state_in;

   logic [CSEL_W-1:0]        clk_ff, clk_in;
   logic [DRIVE_W-1:0]       drive_ff, drive_in;
   logic [FREQ_W-1:0]        f_ff, f_in;
   logic [RDIV_W-1:0]        rdiv_ff, rdiv_in;
   logic signed [DIVD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic [FX_W-1:0]          fx_ff, fx_in;
   logic [MS_W-1:0]          ms_ff, ms_in;
   logic [FVCO_W-1:0]        fvco_ff, fvco_in;
   logic                     retry_ff, retry_in;
   logic [31:0]              a_ff, a_in;
   logic [FX_W-1:0]          rem_ff, rem_in;
   logic [FRAC_W-1:0]        b_ff, b_in;
   logic [FL_W-1:0]          fl_ff, fl_in;

   logic signed [DIVD_W-1:0] num;
   logic [DIVD_W-1:0]        mag;
   logic [29:0]              qadj;
   logic signed [31:0]       fx_sum;
   logic [MS_W-1:0]          ms_clamp;
   logic [MS_W-1:0]          ms_less;

   assign num  = prod_ff + HALF_BILLION;
   assign mag  = num[DIVD_W-1] ? DIVD_W'(-num) : DIVD_W'(num);
   assign qadj = div_rsp.quotient[29:0] + {29'b0, (div_rsp.remainder != '0)};
   assign fx_sum = neg_ff ? ($signed({4'b0, csr.crystal_hz}) - $signed({2'b0, qadj}))
                          : ($signed({4'b0, csr.crystal_hz})
                             + $signed({2'b0, div_rsp.quotient[29:0]}));
   assign ms_less = ms_ff - MS_W'(2);

   always_comb begin
      if (div_rsp.quotient < DIVD_W'(DIV_MIN)) begin
         ms_clamp = DIV_MIN;
      end else if (div_rsp.quotient > DIVD_W'(DIV_MAX)) begin
         ms_clamp = DIV_MAX;
      end else begin
         ms_clamp = div_rsp.quotient[MS_W-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      clk_in     = clk_ff;
      drive_in   = drive_ff;
      f_in       = f_ff;
      rdiv_in    = rdiv_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      fx_in      = fx_ff;
      ms_in      = ms_ff;
      fvco_in    = fvco_ff;
      retry_in   = retry_ff;
      a_in       = a_ff;
      rem_in     = rem_ff;
      b_in       = b_ff;
      fl_in      = fl_ff;
      div_req    = '0;
      emit_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               clk_in   = req_data.clock_select;
               f_in     = req_data.frequency_hz;
               rdiv_in  = '0;
               retry_in = 1'b0;
               case (req_data.clock_select)
                  CSEL_CLK0: drive_in = csr.drive_clk0;
                  CSEL_CLK1: drive_in = csr.drive_clk1;
                  default:   drive_in = csr.drive_clk2;
               endcase
               if (req_data.clock_select != CSEL_NONE) begin
                  state_in = ST_XMUL;
               end
            end
         end
         ST_XMUL: begin
            prod_in  = $signed({1'b0, csr.crystal_hz}) * csr.trim_ppb;
            state_in = ST_XDIV;
         end
         ST_XDIV: begin
            neg_in           = num[DIVD_W-1];
            div_req.start    = 1'b1;
            div_req.dividend = mag;
            div_req.divisor  = BILLION;
            state_in         = ST_XWAIT;
         end
         ST_XWAIT: begin
            if (div_rsp.done) begin
               fx_in    = fx_sum[31] ? '0 : fx_sum[FX_W-1:0];
               state_in = ST_DOUBLE;
            end
         end
         ST_DOUBLE: begin
            if (f_ff < LOW_FREQ_HZ && rdiv_ff != RDIV_MAX) begin
               f_in    = {f_ff[FREQ_W-2:0], 1'b0};
               rdiv_in = rdiv_ff + 1'b1;
            end else begin
               state_in = ST_MSDIV;
            end
         end
         ST_MSDIV: begin
            if (f_ff == '0) begin
               ms_in    = DIV_MAX;
               state_in = ST_VMUL;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIVD_W'(VCO_MAX_HZ);
               div_req.divisor  = DIVR_W'(f_ff);
               state_in         = ST_MSWAIT;
            end
         end
         ST_MSWAIT: begin
            if (div_rsp.done) begin
               ms_in    = ms_clamp + {{(MS_W-1){1'b0}}, ms_clamp[0]};
               state_in = ST_VMUL;
            end
         end
         ST_VMUL: begin
            fvco_in  = FVCO_W'(f_ff) * FVCO_W'(ms_ff);
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            if (fvco_ff < VCO_MIN_HZ && !retry_ff) begin
               ms_in    = (ms_less < DIV_MIN) ? DIV_MIN : ms_less;
               retry_in = 1'b1;
               state_in = ST_VMUL;
            end else begin
               state_in = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (fx_ff == '0) begin
               a_in     = '0;
               b_in     = '0;
               state_in = ST_FDIV;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIVD_W'(fvco_ff);
               div_req.divisor  = DIVR_W'(fx_ff);
               state_in         = ST_AWAIT;
            end
         end
         ST_AWAIT: begin
            if (div_rsp.done) begin
               a_in     = div_rsp.quotient[31:0];
               rem_in   = div_rsp.remainder[FX_W-1:0];
               state_in = ST_BDIV;
            end
         end
         ST_BDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVD_W'({rem_ff, 20'b0}) - DIVD_W'(rem_ff);
            div_req.divisor  = DIVR_W'(fx_ff);
            state_in         = ST_BWAIT;
         end
         ST_BWAIT: begin
            if (div_rsp.done) begin
               b_in     = div_rsp.quotient[FRAC_W-1:0];
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVD_W'({b_ff, 7'b0});
            div_req.divisor  = DIVR_W'(FRAC_DEN);
            state_in         = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (div_rsp.done) begin
               fl_in    = div_rsp.quotient[FL_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            emit_start = 1'b1;
            state_in   = ST_EWAIT;
         end
         ST_EWAIT: begin
            if (!emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      clk_ff   <= clk_in;
      drive_ff <= drive_in;
      f_ff     <= f_in;
      rdiv_ff  <= rdiv_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      fx_ff    <= fx_in;
      ms_ff    <= ms_in;
      fvco_ff  <= fvco_in;
      retry_ff <= retry_in;
      a_ff     <= a_in;
      rem_ff   <= rem_in;
      b_ff     <= b_in;
      fl_ff    <= fl_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign plan.clock_select = clk_ff;
   assign plan.rdiv         = rdiv_ff;
   assign plan.ms           = ms_ff;
   assign plan.a            = a_ff;
   assign plan.b            = b_ff;
   assign plan.fl           = fl_ff;
   assign plan.drive        = drive_ff;

endmodule
`default_nettype wire

// ----- sv/ssop_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssop_emit
   import ssop_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     emit_start,
   input  wire plan_type plan,
   output logic          emit_busy,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   logic              active_ff, active_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              valid_ff, valid_in;
   plan_type          plan_ff;
   rsp_type           data_ff;
   rsp_type           beat;
   logic              load;
   logic              pll_b;
   logic [31:0]       p1_pll;
   logic [26:0]       p2_pll;
   logic [17:0]       p1_ms;
   logic [7:0]        pll_first;
   logic [7:0]        ms_base;

   assign load     = active_ff && (!valid_ff || !rsp_stall);
   assign pll_b    = (plan_ff.clock_select == CSEL_CLK2);
   assign p1_pll   = {plan_ff.a[24:0], 7'b0} + 32'(plan_ff.fl) - 32'd512;
   assign p2_pll   = 27'({plan_ff.b, 7'b0}) - (27'({plan_ff.fl, 20'b0}) - 27'(plan_ff.fl));
   assign p1_ms    = 18'({plan_ff.ms, 7'b0}) - 18'd512;
   assign pll_first = pll_b ? ADDR_PLL_B : ADDR_PLL_A;
   assign ms_base  = ADDR_MS + {3'b0, plan_ff.clock_select, 3'b0};

   // one register write per index
   always_comb begin
      beat.last = (k_ff == LAST_IDX);
      if (k_ff < IDX_W'(8)) begin
         beat.reg_address = pll_first + {5'b0, k_ff[2:0]};
      end else if (k_ff < IDX_W'(16)) begin
         beat.reg_address = ms_base + {5'b0, k_ff[2:0]};
      end else if (k_ff == IDX_W'(16)) begin
         beat.reg_address = ADDR_PHASE + {6'b0, plan_ff.clock_select};
      end else if (k_ff == IDX_W'(17)) begin
         beat.reg_address = ADDR_CTRL + {6'b0, plan_ff.clock_select};
      end else begin
         beat.reg_address = ADDR_PLL_RST;
      end
      unique case (k_ff)
         5'd0:  beat.reg_data = 8'hFF;
         5'd1:  beat.reg_data = 8'hFF;
         5'd2:  beat.reg_data = {6'b0, p1_pll[17:16]};
         5'd3:  beat.reg_data = p1_pll[15:8];
         5'd4:  beat.reg_data = p1_pll[7:0];
         5'd5:  beat.reg_data = {4'hF, p2_pll[19:16]};
         5'd6:  beat.reg_data = p2_pll[15:8];
         5'd7:  beat.reg_data = p2_pll[7:0];
         5'd8:  beat.reg_data = 8'h00;
         5'd9:  beat.reg_data = 8'h01;
         5'd10: beat.reg_data = {1'b0, plan_ff.rdiv, 2'b0, p1_ms[17:16]};
         5'd11: beat.reg_data = p1_ms[15:8];
         5'd12: beat.reg_data = p1_ms[7:0];
         5'd13: beat.reg_data = 8'h00;
         5'd14: beat.reg_data = 8'h00;
         5'd15: beat.reg_data = 8'h00;
         5'd16: beat.reg_data = 8'h00;
         5'd17: beat.reg_data = CTRL_BASE | (pll_b ? CTRL_PLL_B : 8'h00)
                                | {6'b0, plan_ff.drive};
         5'd18: beat.reg_data = pll_b ? RST_PLL_B : RST_PLL_A;
         default: beat.reg_data = 8'h00;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      k_in      = k_ff;
      valid_in  = valid_ff;
      if (emit_start) begin
         active_in = 1'b1;
         k_in      = '0;
      end else if (load) begin
         k_in = k_ff + 1'b1;
         if (k_ff == LAST_IDX) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         k_ff      <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         k_ff      <= k_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_start) begin
         plan_ff <= plan;
      end
      if (load) begin
         data_ff <= beat;
      end
   end

   assign emit_busy = active_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// ----- sv/ssop_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssop_check
   import ssop_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");

   // a real request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.clock_select != CSEL_NONE |=> req_stall)
      else $error("request did not start work");

   // beats of one sequence come back to back until the last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("gap inside write sequence");

   // reset leaves the block idle and empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind synth_single_output_plan ssop_check u_check (.*);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import ssop_pkg::*;

   // clock select three is taken and dropped without any beats
   localparam int unsigned IDLE_SETTLE = 400;
   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned RANDOM_ITEMS = 85;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [XTAL_W-1:0] csr_data = '0;

   synth_single_output_plan uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor's own copy of the configuration
   logic [27:0] plan_crystal;
   logic signed [20:0] plan_trim;
   logic [1:0] plan_drive [3];

   rsp_type pending_writes[$];
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   bit hold_output = 1'b0;
   bit random_stall_on = 1'b1;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // corrected crystal, rounding halves upward
   function automatic longint trimmed_crystal();
      longint num;
      longint q;
      longint r;
      num = longint'(plan_crystal) * longint'(plan_trim) + 64'sd500000000;
      if (num >= 0)
         q = num / 64'sd1000000000;
      else
         q = -((-num + 64'sd999999999) / 64'sd1000000000);
      r = longint'(plan_crystal) + q;
      if (r < 0)
         r = 0;
      return r;
   endfunction

   // eight-byte parameter block for a + b/c with output divide code
   function automatic logic [63:0] param_block(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c, input logic [2:0] rdiv);
      logic [31:0] fl;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [63:0] blk;
      fl = (c != 0) ? 32'((64'd128 * b) / c) : 32'd0;
      p1 = 32'd128 * a + fl - 32'd512;
      p2 = 32'd128 * b - c * fl;
      blk[63:56] = c[15:8];
      blk[55:48] = c[7:0];
      blk[47:40] = {1'b0, rdiv, 2'b00, p1[17:16]};
      blk[39:32] = p1[15:8];
      blk[31:24] = p1[7:0];
      blk[23:16] = {c[19:16], p2[19:16]};
      blk[15:8] = p2[15:8];
      blk[7:0] = p2[7:0];
      return blk;
   endfunction

   task automatic push_write(input logic [7:0] addr, input logic [7:0] value,
                             input bit fin);
      rsp_type w;
      w.reg_address = addr;
      w.reg_data = value;
      w.last = fin;
      pending_writes.push_back(w);
   endtask

   // frequency plan: queue the 19 register writes a request causes
   task automatic plan_frequency(input req_type req);
      logic [63:0] f;
      logic [2:0] rdiv;
      longint unsigned ms;
      longint unsigned fvco;
      longint unsigned fx;
      logic [31:0] a;
      logic [31:0] b;
      logic [63:0] blk;
      logic [7:0] pll_first;
      logic [7:0] ctrl;
      int unsigned clk;
      f = req.frequency_hz;
      rdiv = 3'd0;
      a = 0;
      b = 0;
      clk = req.clock_select;
      if (req.clock_select == CSEL_NONE)
         return;
      fx = longint'(trimmed_crystal());
      while (f < 500000 && rdiv < 3'd7) begin
         f = f << 1;
         rdiv++;
      end
      ms = (f == 0) ? 1800 : 64'd900000000 / f;
      if (ms < 6) ms = 6;
      if (ms > 1800) ms = 1800;
      if (ms[0]) ms++;
      fvco = f * ms;
      if (fvco < 64'd600000000) begin
         ms -= 2;
         if (ms < 6) ms = 6;
         fvco = f * ms;
      end
      if (fx != 0) begin
         a = 32'(fvco / fx);
         b = 32'(((fvco - longint'(a) * fx) * 64'd1048575) / fx);
      end
      pll_first = (req.clock_select == CSEL_CLK2) ? ADDR_PLL_B : ADDR_PLL_A;
      blk = param_block(a, b, 32'd1048575, 3'd0);
      for (int i = 0; i < 8; i++)
         push_write(pll_first + 8'(i), blk[63 - 8 * i -: 8], 1'b0);
      blk = param_block(32'(ms), 32'd0, 32'd1, rdiv);
      for (int i = 0; i < 8; i++)
         push_write(ADDR_MS + 8'(8 * clk + i), blk[63 - 8 * i -: 8], 1'b0);
      push_write(ADDR_PHASE + 8'(clk), 8'h00, 1'b0);
      ctrl = CTRL_BASE | {6'd0, plan_drive[clk]};
      if (req.clock_select == CSEL_CLK2)
         ctrl |= CTRL_PLL_B;
      push_write(ADDR_CTRL + 8'(clk), ctrl, 1'b0);
      push_write(ADDR_PLL_RST, (req.clock_select == CSEL_CLK2) ? RST_PLL_B : RST_PLL_A,
                 1'b1);
   endtask

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // output side: check each accepted beat against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected beat addr %0d", rsp_data.reg_address));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_data.reg_address !== want.reg_address)
               report_mismatch($sformatf("reg_address %0d want %0d",
                                         rsp_data.reg_address, want.reg_address));
            if (rsp_data.reg_data !== want.reg_data)
               report_mismatch($sformatf("reg_data %h want %h at addr %0d",
                                         rsp_data.reg_data, want.reg_data,
                                         want.reg_address));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %b want %b at addr %0d",
                                         rsp_data.last, want.last, want.reg_address));
         end
      end
   end

   // receiver stall: random gaps, or a forced long hold-off
   initial begin
      int unsigned n;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
         end else if (random_stall_on && $urandom_range(0, 3) == 0) begin
            n = gap_length();
            if (n == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles with no accepted beat on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[synth_single_output_plan] ERROR");
         $finish;
      end
   end

   // valid stays up between writes of one batch; the caller drops it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [27:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      case (idx)
         CSR_CRYSTAL: plan_crystal = value;
         CSR_TRIM: plan_trim = value[20:0];
         CSR_DRIVE0: plan_drive[0] = value[1:0];
         CSR_DRIVE1: plan_drive[1] = value[1:0];
         CSR_DRIVE2: plan_drive[2] = value[1:0];
         default: ;
      endcase
   endtask

   // send one beat; the prediction is queued at acceptance
   task automatic send_request(input logic [1:0] clk_sel, input logic [27:0] freq,
                               input bit with_gap);
      req_type r;
      r.clock_select = clk_sel;
      r.frequency_hz = freq;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      plan_frequency(r);
      @(negedge clock);
      if (with_gap) begin
         int unsigned g;
         g = gap_length();
         if (g != 0) begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   endtask

   task automatic drain_writes();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_writes.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      // a dropped clock-three request may still be in the pipe
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic set_config(input logic [27:0] xtal, input logic [20:0] trim,
                             input logic [1:0] d0, input logic [1:0] d1,
                             input logic [1:0] d2);
      drain_writes();
      write_csr(CSR_CRYSTAL, xtal);
      write_csr(CSR_TRIM, {7'd0, trim});
      write_csr(CSR_DRIVE0, {26'd0, d0});
      write_csr(CSR_DRIVE1, {26'd0, d1});
      write_csr(CSR_DRIVE2, {26'd0, d2});
      csr_valid <= 1'b0;
   endtask

   typedef struct {
      logic [1:0] clk_sel;
      logic [27:0] freq;
   } directed_row;

   // directed rows: field extremes, every clock, low-frequency doubling,
   // zero frequency, dropped clock three, divider clamps
   directed_row directed_rows [] = '{
      '{CSEL_CLK0, 28'd10000000},
      '{CSEL_CLK1, 28'd7000000},
      '{CSEL_CLK2, 28'd144000000},
      '{CSEL_CLK0, 28'd0},
      '{CSEL_CLK1, 28'd1},
      '{CSEL_NONE, 28'd14000000},
      '{CSEL_CLK2, 28'd225000000},
      '{CSEL_CLK0, 28'hFFFFFFF},
      '{CSEL_CLK1, 28'd499999},
      '{CSEL_CLK2, 28'd500000},
      '{CSEL_CLK0, 28'd3906},
      '{CSEL_CLK1, 28'd150000000},
      '{CSEL_CLK2, 28'd333333},
      '{CSEL_NONE, 28'hFFFFFFF},
      '{CSEL_CLK0, 28'(600000000 / 1800)}
   };

   function automatic logic [27:0] random_freq();
      case ($urandom_range(0, 5))
         0: return 28'($urandom_range(0, 500000));
         1: return 28'($urandom_range(0, 1000));
         2: return 28'($urandom_range(220000000, 28'hFFFFFFF));
         default: return 28'($urandom_range(1, 225000000));
      endcase
   endfunction

   initial begin
      plan_crystal = 28'd25000000;
      plan_trim = 21'sd0;
      plan_drive[0] = 2'd3;
      plan_drive[1] = 2'd3;
      plan_drive[2] = 2'd3;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values first, then the directed table
      foreach (directed_rows[i])
         send_request(directed_rows[i].clk_sel, directed_rows[i].freq, 1'b1);

      // configuration extremes, including the zero-crystal corner
      set_config(28'd1000000, 21'h0F4240, 2'd0, 2'd1, 2'd2);
      send_request(CSEL_CLK0, 28'd10000000, 1'b0);
      send_request(CSEL_CLK2, 28'd100, 1'b0);
      set_config(28'hFFFFFFF, 21'h10_0000, 2'd1, 2'd2, 2'd0);
      send_request(CSEL_CLK1, 28'd28000000, 1'b0);
      send_request(CSEL_CLK2, 28'd1, 1'b0);
      set_config(28'd0, 21'h1FFFFF, 2'd2, 2'd0, 2'd1);
      send_request(CSEL_CLK0, 28'd5000000, 1'b0);
      send_request(CSEL_CLK2, 28'd0, 1'b0);
      set_config(28'd200000000, 21'h0F0BDC, 2'd3, 2'd3, 2'd3);
      send_request(CSEL_CLK1, 28'd123456789, 1'b0);

      // long hold-off at the receiver while requests keep coming
      hold_output = 1'b1;
      random_stall_on = 1'b0;
      fork
         begin
            repeat (1500) @(negedge clock);
            hold_output = 1'b0;
         end
         for (int i = 0; i < 4; i++)
            send_request(2'($urandom_range(0, 2)), random_freq(), 1'b0);
      join
      random_stall_on = 1'b1;

      // random requests with configuration changes between phases
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 29) begin
            set_config(28'($urandom_range(1000000, 200000000)),
                       21'($urandom_range(0, 2000000) - 1000000),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)));
         end
         if (i == 50)
            drain_writes();
         send_request(($urandom_range(0, 15) == 0) ? CSEL_NONE : 2'($urandom_range(0, 2)),
                      random_freq(), 1'b1);
      end

      drain_writes();
      if (fail_count == 0 && pending_writes.size() == 0)
         $display("[synth_single_output_plan] OK");
      else
         $display("[synth_single_output_plan] ERROR");
      $finish;
   end

endmodule
